### sv/kdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdec_pkg: shared types and constants of the keypad debounce entry controller
// holds field widths, register indexes, phase codes and the debounce interface
// ----------------------------------------------------------------------------
package kdec_pkg;

    // field widths fixed by the item format
    localparam int MATRIX_W   = 12;
    localparam int CODE_W     = 4;
    localparam int DIGIT_W    = 4;
    localparam int SETPOINT_W = 7;
    localparam int PHASE_W    = 2;
    localparam int STABLE_W   = 9;
    localparam int HOLD_W     = 12;
    localparam int DELAY_W    = 8;

    // configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_MEDIUM   = 2'd2;
    localparam logic [1:0] REG_MAX      = 2'd3;

    // phase codes as seen on the result
    localparam logic [PHASE_W-1:0] PHASE_CODE_DISPLAY = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_INPUT   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SLEEP   = 2'd2;

    typedef enum logic [2:0] {
        PH_DISPLAY = 3'b001,
        PH_INPUT   = 3'b010,
        PH_SLEEP   = 3'b100
    } t_phase;

    // debounced key presented to the phase logic
    typedef struct packed {
        logic              act;
        logic [CODE_W-1:0] key;
    } t_deb;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_DISPLAY: code = PHASE_CODE_DISPLAY;
            PH_INPUT:   code = PHASE_CODE_INPUT;
            PH_SLEEP:   code = PHASE_CODE_SLEEP;
            default:    code = PHASE_CODE_DISPLAY;
        endcase
        return code;
    endfunction

endpackage

### sv/kdec_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdec_debounce: matrix scan and debounce
// picks one key of the sample by scan priority and counts stable ticks
// ----------------------------------------------------------------------------
module kdec_debounce
    import kdec_pkg::*;
#(
    parameter int KEY_ROWS = 4,
    parameter int KEY_COLS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [MATRIX_W-1:0] i_key_matrix,
    input  logic [DELAY_W-1:0]  i_debounce_delay,
    output t_deb                o_deb
);

    localparam logic [STABLE_W-1:0] STABLE_MAX = '1;

    logic [CODE_W-1:0]   r_raw, n_raw;
    logic [STABLE_W-1:0] r_stable, n_stable;
    logic [STABLE_W-1:0] w_stable_eff;
    logic [CODE_W-1:0]   w_raw;

    // reverse priority order: last hit wins, so row 0 column 1 ends on top
    always_comb begin
        int pos;
        w_raw = '0;
        for (int r = KEY_ROWS - 1; r >= 0; r--) begin
            for (int c = KEY_COLS - 1; c >= 2; c--) begin
                pos = r * KEY_COLS + c;
                if (pos < MATRIX_W && i_key_matrix[4'(pos)]) begin
                    w_raw = CODE_W'(pos + 1);
                end
            end
            pos = r * KEY_COLS;
            if (pos < MATRIX_W && i_key_matrix[4'(pos)]) begin
                w_raw = CODE_W'(pos + 1);
            end
            pos = r * KEY_COLS + 1;
            if (KEY_COLS > 1 && pos < MATRIX_W && i_key_matrix[4'(pos)]) begin
                w_raw = CODE_W'(pos + 1);
            end
        end
    end

    always_comb begin
        w_stable_eff = (w_raw != r_raw) ? '0 : r_stable;
        o_deb.act    = w_stable_eff > STABLE_W'(i_debounce_delay);
        o_deb.key    = w_raw;
        n_raw        = w_raw;
        n_stable     = (w_stable_eff != STABLE_MAX) ? w_stable_eff + 1'b1 : w_stable_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= '0;
            r_stable <= '0;
        end else if (i_step) begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
        end
    end

endmodule

### sv/keypad_debounce_entry_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_entry_controller_unit: keypad scan, debounce and entry
// one matrix sample per scan tick in, one phase and setpoint result out
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one 12-bit key matrix sample per scan tick, bit row*cols+col
//   set while that key is closed. m_axis returns one result per sample: phase,
//   setpoint in tenths, both entered digits, debounced key code and the
//   display-off and setpoint-changed pulses.
//   the apb port holds debounce_delay, long_hold, medium_hold and max_setting
//   at byte addresses 0, 4, 8 and 12; write them only while no sample is in
//   flight. pready is tied high, reads return the register value.
// pipeline and throughput
//   a sample is taken into the input register and processed from there into
//   the result register, which drives m_axis_tvalid.
//   one sample per cycle is sustained while m_axis_tready stays high: the only
//   loop is the state update from the input register to the result register.
// reset and stall
//   synchronous active-low reset returns registers to their defaults, the
//   phase to display and all counters, digits and setpoint to zero.
//   while m_axis_tready is low the result waits and one more sample is held
//   in the input register; s_axis_tready drops only when both are full.
// ----------------------------------------------------------------------------
module keypad_debounce_entry_controller_unit
    import kdec_pkg::*;
#(
    parameter int KEY_ROWS = 4,
    parameter int KEY_COLS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] key_matrix, [15:12] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] phase, [8:2] setpoint_tenths,
                                        // [12:9] units digit, [16:13] tenths digit,
                                        // [20:17] stable_key, [21] display_off,
                                        // [22] setpoint_changed, [23] zero
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // key codes of the bottom row, row*cols + col + 1
    localparam int CODE_STAR = 3 * KEY_COLS + 1;
    localparam int CODE_ZERO = 3 * KEY_COLS + 2;
    localparam int CODE_HASH = 3 * KEY_COLS + 3;
    // only the 12 sampled positions can ever produce a code
    localparam int NUM_POS   = (KEY_ROWS * KEY_COLS < MATRIX_W) ?
                               KEY_ROWS * KEY_COLS : MATRIX_W;
    localparam logic [HOLD_W-1:0]     HOLD_MAX     = '1;
    localparam logic [7:0]            SETPOINT_TOP = 8'd99;

    // configuration registers
    logic [DELAY_W-1:0]    r_debounce_delay;
    logic [HOLD_W-1:0]     r_long_hold;
    logic [HOLD_W-1:0]     r_medium_hold;
    logic [SETPOINT_W-1:0] r_max_setting;

    // input register
    logic                r_in_vld;
    logic [MATRIX_W-1:0] r_in_matrix;

    // controller state
    logic [CODE_W-1:0]     r_handled, n_handled;
    logic [HOLD_W-1:0]     r_hold, n_hold;
    t_phase                r_phase, n_phase;
    logic [DIGIT_W-1:0]    r_digit0, n_digit0;
    logic [DIGIT_W-1:0]    r_digit1, n_digit1;
    logic                  r_slot, n_slot;
    logic [SETPOINT_W-1:0] r_setpoint, n_setpoint;
    logic                  n_off, n_changed;

    // result register
    logic                  r_out_vld;
    logic [PHASE_W-1:0]    r_out_phase;
    logic [SETPOINT_W-1:0] r_out_setpoint;
    logic [DIGIT_W-1:0]    r_out_digit0;
    logic [DIGIT_W-1:0]    r_out_digit1;
    logic [CODE_W-1:0]     r_out_key;
    logic                  r_out_off;
    logic                  r_out_changed;

    logic                w_process;
    logic                w_cfg_wr;
    t_deb                w_deb;
    logic [DIGIT_W-1:0]  w_prev_digit;
    logic                w_prev_is_digit;
    logic [HOLD_W-1:0]   w_hold_inc;
    logic [7:0]          w_sum;
    logic                w_update;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // a held sample moves on when the result register is free or drains
    assign w_process     = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_process;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_changed, r_out_off, r_out_key, r_out_digit1,
                            r_out_digit0, r_out_setpoint, r_out_phase};

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_delay <= DELAY_W'(10);
            r_long_hold      <= HOLD_W'(600);
            r_medium_hold    <= HOLD_W'(200);
            r_max_setting    <= SETPOINT_W'(23);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_DEBOUNCE: r_debounce_delay <= pwdata[DELAY_W-1:0];
                REG_LONG:     r_long_hold      <= pwdata[HOLD_W-1:0];
                REG_MEDIUM:   r_medium_hold    <= pwdata[HOLD_W-1:0];
                REG_MAX:      r_max_setting    <= pwdata[SETPOINT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = {{(32-DELAY_W){1'b0}}, r_debounce_delay};
            REG_LONG:     prdata = {{(32-HOLD_W){1'b0}}, r_long_hold};
            REG_MEDIUM:   prdata = {{(32-HOLD_W){1'b0}}, r_medium_hold};
            REG_MAX:      prdata = {{(32-SETPOINT_W){1'b0}}, r_max_setting};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_matrix <= s_axis_tdata[MATRIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // scan and debounce
    // ------------------------------------------------------------------
    kdec_debounce #(
        .KEY_ROWS (KEY_ROWS),
        .KEY_COLS (KEY_COLS)
    ) u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (w_process),
        .i_key_matrix     (r_in_matrix),
        .i_debounce_delay (r_debounce_delay),
        .o_deb            (w_deb)
    );

    // digit of the previously handled key, '0' sits at row 3 column 1
    always_comb begin
        w_prev_digit    = '0;
        w_prev_is_digit = 1'b0;
        for (int p = 0; p < NUM_POS; p++) begin
            if (r_handled == CODE_W'(p + 1)) begin
                if (p + 1 == CODE_ZERO) begin
                    w_prev_digit    = '0;
                    w_prev_is_digit = 1'b1;
                end else if (p / KEY_COLS < 3 && p % KEY_COLS < 3) begin
                    w_prev_digit    = DIGIT_W'((p / KEY_COLS) * 3 + (p % KEY_COLS) + 1);
                    w_prev_is_digit = 1'b1;
                end
            end
        end
    end

    assign w_hold_inc = (r_hold != HOLD_MAX) ? r_hold + 1'b1 : r_hold;

    // ------------------------------------------------------------------
    // phase machine and entry
    // ------------------------------------------------------------------
    always_comb begin
        n_handled = r_handled;
        n_hold    = r_hold;
        n_phase   = r_phase;
        n_digit0  = r_digit0;
        n_digit1  = r_digit1;
        n_slot    = r_slot;
        n_off     = 1'b0;
        w_update  = 1'b0;
        if (w_deb.act) begin
            if (w_deb.key != '0) begin
                if (32'(w_deb.key) == CODE_STAR && w_deb.key == r_handled) begin
                    // long star: sleep
                    n_hold = w_hold_inc;
                    if (w_hold_inc >= r_long_hold) begin
                        n_phase = PH_SLEEP;
                        n_off   = 1'b1;
                        n_hold  = '0;
                    end
                end else if (32'(w_deb.key) == CODE_HASH && w_deb.key == r_handled) begin
                    // long hash: input, counter keeps running
                    n_hold = w_hold_inc;
                    if (w_hold_inc >= r_long_hold) begin
                        n_phase = PH_INPUT;
                    end
                end else begin
                    // new press, or one key replacing another
                    n_hold = '0;
                end
            end else begin
                // release of the handled key
                if (r_handled != '0) begin
                    if (32'(r_handled) == CODE_STAR) begin
                        if (r_hold >= r_medium_hold) begin
                            n_phase = PH_INPUT;
                            n_off   = 1'b1;
                        end else if (r_phase == PH_INPUT) begin
                            // short star deletes the last digit
                            if (r_digit1 != '0) begin
                                n_digit1 = '0;
                                n_slot   = 1'b1;
                            end else begin
                                n_digit0 = '0;
                                n_slot   = 1'b0;
                            end
                            w_update = 1'b1;
                        end
                    end else if (r_phase == PH_INPUT) begin
                        if (r_hold <= r_long_hold && 32'(r_handled) == CODE_HASH) begin
                            n_phase = PH_DISPLAY;
                        end else if (32'(r_handled) != CODE_HASH && w_prev_is_digit) begin
                            if (r_slot) begin
                                n_digit1 = w_prev_digit;
                            end else begin
                                n_digit0 = w_prev_digit;
                            end
                            n_slot   = !r_slot;
                            w_update = 1'b1;
                        end
                    end
                end
                n_hold = '0;
            end
            n_handled = w_deb.key;
        end
    end

    // setpoint = first*10 + second, clamped to max_setting
    always_comb begin
        w_sum      = 8'({n_digit0, 3'b000}) + 8'({n_digit0, 1'b0}) + 8'(n_digit1);
        n_setpoint = r_setpoint;
        if (w_update) begin
            n_setpoint = (w_sum > 8'(r_max_setting)) ? r_max_setting : w_sum[SETPOINT_W-1:0];
        end
        n_changed = w_update;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handled  <= '0;
            r_hold     <= '0;
            r_phase    <= PH_DISPLAY;
            r_digit0   <= '0;
            r_digit1   <= '0;
            r_slot     <= 1'b0;
            r_setpoint <= '0;
        end else if (w_process) begin
            r_handled  <= n_handled;
            r_hold     <= n_hold;
            r_phase    <= n_phase;
            r_digit0   <= n_digit0;
            r_digit1   <= n_digit1;
            r_slot     <= n_slot;
            r_setpoint <= n_setpoint;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_process) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_out_phase    <= phase_code(n_phase);
            r_out_setpoint <= n_setpoint;
            r_out_digit0   <= n_digit0;
            r_out_digit1   <= n_digit1;
            r_out_key      <= n_handled;
            r_out_off      <= n_off;
            r_out_changed  <= n_changed;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_off_leaves_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_off) |-> (r_out_phase != PHASE_CODE_DISPLAY))
        else $error("display-off pulse with display phase");

    a_setpoint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (8'(r_setpoint) <= SETPOINT_TOP) && (r_digit0 <= 4'd9) && (r_digit1 <= 4'd9))
        else $error("entry state out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_process_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> r_out_vld)
        else $error("processed sample produced no result");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keypad debounce entry controller
// feeds key matrix samples as press and release sessions with random bounce
// and stalls on both streams, predicts every result with a cycle model of
// the scan, debounce and phase logic, and compares each result field by field
// ----------------------------------------------------------------------------
module tb;
    import kdec_pkg::*;

    localparam int ROWS = 4;
    localparam int COLS = 3;
    localparam int KEYS = ROWS * COLS;

    // key position codes, row*cols+col+1
    localparam logic [CODE_W-1:0] KEY_NONE = 4'd0;
    localparam logic [CODE_W-1:0] KEY_STAR = 4'd10;
    localparam logic [CODE_W-1:0] KEY_ZERO = 4'd11;
    localparam logic [CODE_W-1:0] KEY_HASH = 4'd12;
    localparam logic [DIGIT_W-1:0] NO_DIGIT = 4'd15;

    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 1000;

    // result transaction as it sits on m_axis_tdata, lowest field last
    typedef struct packed {
        logic                  pad;
        logic                  changed;
        logic                  blank;
        logic [CODE_W-1:0]     key;
        logic [DIGIT_W-1:0]    second;
        logic [DIGIT_W-1:0]    first;
        logic [SETPOINT_W-1:0] setpoint;
        logic [PHASE_W-1:0]    phase;
    } t_result;

    // ------------------------------------------------------------------------
    // entry_checker: tracks the controller state per accepted sample and
    // holds the results it expects, oldest first
    // ------------------------------------------------------------------------
    class entry_checker;
        // register copies
        logic [DELAY_W-1:0]    debounce_delay;
        logic [HOLD_W-1:0]     long_hold;
        logic [HOLD_W-1:0]     medium_hold;
        logic [SETPOINT_W-1:0] max_setting;
        // scan and debounce state
        logic [CODE_W-1:0]     raw_last;
        logic [STABLE_W-1:0]   stable_cnt;
        logic [CODE_W-1:0]     acted_key;
        logic [HOLD_W-1:0]     hold_cnt;
        // entry state
        logic [PHASE_W-1:0]    phase;
        logic [DIGIT_W-1:0]    digits [2];
        logic                  slot;
        logic [SETPOINT_W-1:0] setpoint;
        logic                  blank;
        logic                  changed;
        t_result               expected_results [$];
        int                    fails;
        int                    checked;
        int                    updates;
        int                    blanks;

        function new();
            debounce_delay = 8'd10;
            long_hold      = 12'd600;
            medium_hold    = 12'd200;
            max_setting    = 7'd23;
            raw_last       = KEY_NONE;
            stable_cnt     = '0;
            acted_key      = KEY_NONE;
            hold_cnt       = '0;
            phase          = PHASE_CODE_DISPLAY;
            digits[0]      = '0;
            digits[1]      = '0;
            slot           = 1'b0;
            setpoint       = '0;
            fails          = 0;
            checked        = 0;
            updates        = 0;
            blanks         = 0;
        endfunction

        // returns the value the register keeps after the write
        function logic [31:0] set_reg(logic [1:0] idx, logic [31:0] val);
            logic [31:0] kept;
            kept = '0;
            case (idx)
                REG_DEBOUNCE: begin
                    debounce_delay = val[DELAY_W-1:0];
                    kept = 32'(debounce_delay);
                end
                REG_LONG: begin
                    long_hold = val[HOLD_W-1:0];
                    kept = 32'(long_hold);
                end
                REG_MEDIUM: begin
                    medium_hold = val[HOLD_W-1:0];
                    kept = 32'(medium_hold);
                end
                REG_MAX: begin
                    max_setting = val[SETPOINT_W-1:0];
                    kept = 32'(max_setting);
                end
            endcase
            return kept;
        endfunction

        // rows top down, inside a row the middle column wins, then left, right
        function logic [CODE_W-1:0] scan_key(logic [MATRIX_W-1:0] m);
            for (int r = 0; r < ROWS; r++) begin
                if (m[r*COLS+1]) return CODE_W'(r*COLS + 2);
                if (m[r*COLS])   return CODE_W'(r*COLS + 1);
                if (m[r*COLS+2]) return CODE_W'(r*COLS + 3);
            end
            return KEY_NONE;
        endfunction

        // the nine digit keys carry their own code, the zero key sits on row 3
        function logic [DIGIT_W-1:0] digit_value(logic [CODE_W-1:0] code);
            if (code == KEY_ZERO) return '0;
            if (code != KEY_NONE && code <= 4'd9) return code;
            return NO_DIGIT;
        endfunction

        function void refresh_setpoint();
            int v;
            v = digits[0] * 10 + digits[1];
            setpoint = (v > max_setting) ? max_setting : SETPOINT_W'(v);
            changed = 1'b1;
            updates++;
        endfunction

        function void act_on(logic [CODE_W-1:0] key);
            logic [CODE_W-1:0]  prev;
            logic [DIGIT_W-1:0] d;
            prev = acted_key;
            if (key != KEY_NONE) begin
                if (key == KEY_STAR && prev == KEY_STAR) begin
                    if (hold_cnt != '1) hold_cnt += 1'b1;
                    if (hold_cnt >= long_hold) begin
                        phase    = PHASE_CODE_SLEEP;
                        blank    = 1'b1;
                        hold_cnt = '0;
                    end
                end else if (key == KEY_HASH && prev == KEY_HASH) begin
                    if (hold_cnt != '1) hold_cnt += 1'b1;
                    if (hold_cnt >= long_hold) phase = PHASE_CODE_INPUT;
                end else begin
                    // fresh key, or a direct change from another one
                    hold_cnt = '0;
                end
            end else begin
                if (prev == KEY_STAR) begin
                    if (hold_cnt >= medium_hold) begin
                        phase = PHASE_CODE_INPUT;
                        blank = 1'b1;
                    end else if (phase == PHASE_CODE_INPUT) begin
                        // short star deletes the last digit entered
                        if (digits[1] != '0) begin
                            digits[1] = '0;
                            slot = 1'b1;
                        end else begin
                            digits[0] = '0;
                            slot = 1'b0;
                        end
                        refresh_setpoint();
                    end
                end else if (prev != KEY_NONE && phase == PHASE_CODE_INPUT) begin
                    if (prev == KEY_HASH) begin
                        if (hold_cnt <= long_hold) phase = PHASE_CODE_DISPLAY;
                    end else begin
                        d = digit_value(prev);
                        if (d != NO_DIGIT) begin
                            digits[slot] = d;
                            slot = ~slot;
                            refresh_setpoint();
                        end
                    end
                end
                hold_cnt = '0;
            end
            acted_key = key;
        endfunction

        // one scan tick per accepted sample
        function void note_sample(logic [MATRIX_W-1:0] m);
            logic [CODE_W-1:0] raw;
            t_result           r;
            raw     = scan_key(m);
            blank   = 1'b0;
            changed = 1'b0;
            if (raw != raw_last) stable_cnt = '0;
            if (stable_cnt > debounce_delay) act_on(raw);
            raw_last = raw;
            if (stable_cnt != '1) stable_cnt += 1'b1;
            if (blank) blanks++;
            r.pad      = 1'b0;
            r.changed  = changed;
            r.blank    = blank;
            r.key      = acted_key;
            r.second   = digits[1];
            r.first    = digits[0];
            r.setpoint = setpoint;
            r.phase    = phase;
            expected_results.push_back(r);
        endfunction

        task report(string msg);
            if (fails < 40) $display("ERROR: %s", msg);
            fails++;
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 checked, field, got, want));
        endtask

        task check_result(logic [23:0] data);
            t_result got;
            t_result want;
            got = data;
            checked++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d arrived with no sample pending", checked));
                return;
            end
            want = expected_results.pop_front();
            compare("phase", got.phase, want.phase);
            compare("setpoint_tenths", got.setpoint, want.setpoint);
            compare("units digit", got.first, want.first);
            compare("tenths digit", got.second, want.second);
            compare("stable_key", got.key, want.key);
            compare("display_off", got.blank, want.blank);
            compare("setpoint_changed", got.changed, want.changed);
            compare("pad bit", got.pad, want.pad);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [11:0] key_matrix, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // phase, setpoint, digits, key, pulses
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    entry_checker sb;

    // stimulus bookkeeping
    int samples_sent = 0;
    int settings     = 1;   // the reset values count as the first setting
    int cur_deb      = 10;
    int cur_long     = 600;
    int cur_med      = 200;
    bit src_steady   = 1'b0;
    bit snk_steady   = 1'b0;
    int quiet_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    keypad_debounce_entry_controller_unit u_dut (.*);

    // ------------------------------------------------------------------------
    // monitor: every transaction seen at a rising edge goes to the checker,
    // and the watchdog counts edges on which neither stream moved
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[MATRIX_W-1:0]);
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random back-pressure with occasional stretches of none
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int served;
        served = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (served % 48 == 0) snk_steady = ($urandom_range(2, 0) == 0);
            gap = snk_steady ? 0 : $urandom_range(9, 0);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            served++;
        end
    end

    // ------------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------------

    // one sample transaction, preceded by a random gap unless streaming steady
    task automatic send_sample(logic [MATRIX_W-1:0] m);
        int gap;
        gap = src_steady ? 0 : $urandom_range(9, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, m};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // scan priority of a matrix position: lower is picked first
    function automatic int scan_rank(int pos);
        int col;
        col = pos % COLS;
        return (pos / COLS) * COLS + ((col == 1) ? 0 : (col == 0) ? 1 : col);
    endfunction

    // matrix that scans to the given key, at times with extra keys closed
    // that the scan order hides behind it
    function automatic logic [MATRIX_W-1:0] pattern_for(logic [CODE_W-1:0] code);
        logic [MATRIX_W-1:0] m;
        logic [MATRIX_W-1:0] hidden;
        int                  pos;
        m      = '0;
        hidden = '0;
        if (code == KEY_NONE) return m;
        pos = code - 1;
        for (int i = 0; i < KEYS; i++)
            if (scan_rank(i) > scan_rank(pos)) hidden[i] = 1'b1;
        m[pos] = 1'b1;
        if ($urandom_range(2, 0) == 0) m |= hidden & MATRIX_W'($urandom);
        return m;
    endfunction

    task automatic press(logic [CODE_W-1:0] code, int ticks);
        repeat (ticks) send_sample(pattern_for(code));
    endtask

    // press and release sessions with random keys and hold lengths around
    // the debounce window and both hold thresholds, mixed with bounce noise
    // and presses too short to register
    task automatic key_sessions(int budget);
        int                start_cnt;
        int                kind;
        int                h;
        logic [CODE_W-1:0] code;
        start_cnt = samples_sent;
        while (samples_sent - start_cnt < budget) begin
            src_steady = ($urandom_range(3, 0) == 0);
            kind = $urandom_range(99, 0);
            case ($urandom_range(3, 0))
                0:       code = KEY_STAR;
                1:       code = KEY_HASH;
                default: code = CODE_W'($urandom_range(11, 1));
            endcase
            if (kind < 8) begin
                // contact bounce, any keys at all
                repeat ($urandom_range(3, 1)) send_sample(MATRIX_W'($urandom));
            end else if (kind < 16) begin
                // released before the debounce window closes
                press(code, $urandom_range(cur_deb + 1, 1));
            end else begin
                case ($urandom_range(5, 0))
                    0, 1:    h = $urandom_range(cur_med, 0);
                    2:       h = cur_med - 1 + $urandom_range(2, 0);
                    3:       h = cur_long - 1 + $urandom_range(2, 0);
                    4:       h = cur_long + $urandom_range(8, 1);
                    default: h = $urandom_range(3, 0);
                endcase
                if (h < 0) h = 0;
                // the hold count at release equals the ticks beyond the window
                press(code, cur_deb + 2 + h);
            end
            // mostly a clean release, sometimes rolling straight to the next key
            if ($urandom_range(9, 0) != 0) press(KEY_NONE, cur_deb + 2 + $urandom_range(3, 0));
        end
    endtask

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------

    // write one register, then read it back in the same selection
    task automatic set_register(logic [1:0] idx, logic [31:0] val);
        logic [31:0] kept;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // the register takes the value at this edge
        kept = sb.set_reg(idx, val);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== kept)
            sb.report($sformatf("register %0d reads %0h, expected %0h", idx, prdata, kept));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and let every sample in flight come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(int deb, int lng, int med, int maxv);
        settle();
        set_register(REG_DEBOUNCE, 32'(deb));
        set_register(REG_LONG, 32'(lng));
        set_register(REG_MEDIUM, 32'(med));
        set_register(REG_MAX, 32'(maxv));
        cur_deb  = deb;
        cur_long = lng;
        cur_med  = med;
        settings++;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes under the reset settings: empty, full, alternating,
        // then each key position alone
        send_sample('0);
        send_sample('1);
        send_sample(12'h555);
        send_sample(12'hAAA);
        for (int i = 0; i < KEYS; i++) send_sample(MATRIX_W'(1) << i);
        send_sample('1);
        send_sample('0);

        // short thresholds, widest clamp
        configure(1, 15, 6, 99);
        key_sessions(240);
        // smallest nonzero holds, setpoint clamped to zero
        configure(0, 1, 1, 0);
        key_sessions(120);
        // zero holds compare as is, clamp above the two-digit range
        configure(2, 0, 0, 127);
        key_sessions(120);
        configure(3, 25, 10, 45);
        key_sessions(220);

        // hash held until the count equals long_hold enters input, and its
        // release at exactly that count returns to display; then star held
        // to the limit enters sleep
        configure(8, 20, 12, 23);
        src_steady = 1'b0;
        press(KEY_NONE, 8 + 2);
        press(KEY_HASH, 8 + 2 + 20);
        press(KEY_NONE, 8 + 4);
        press(KEY_STAR, 8 + 2 + 20);
        press(KEY_NONE, 8 + 4);

        // a new clamp applies from the next setpoint update on
        configure(0, 8, 4, 60);
        key_sessions(220);
        settle();

        $display("run covered %0d key samples and %0d results over %0d register settings",
                 samples_sent, sb.checked, settings);
        $display("setpoint updates predicted: %0d, display blank pulses: %0d",
                 sb.updates, sb.blanks);
        if (sb.fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", sb.fails);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
